// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the relay level controller checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/brlc_pkg.sv =====
// ----------------------------------------------------------------------------
// Relay level controller package
// Widths, codes, register layout and the level power table.
// ----------------------------------------------------------------------------
`default_nettype none

package brlc_pkg;

  localparam int LEVELS_DEFAULT = 8;
  localparam int TABLE_SIZE     = 16;

  localparam int LVL_W     = 3;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 4;
  localparam int SOC_W     = 10;
  localparam int PWR_W     = 16;
  localparam int CUR_W     = 19;
  localparam int WATT_W    = 15;
  localparam int TICKS_W   = 4;
  localparam int DEC_W     = 3;

  localparam int PW_SUM_W  = 17;
  localparam int GB_W      = 27;
  localparam int GBB_W     = 28;
  localparam int LOAD_W    = 26;
  localparam int EXCESS_W  = 28;
  localparam int BUDGET_W  = 29;
  localparam int PWR_TBL_W = 14;
  localparam int PWR_MW_W  = 24;

  localparam int MW_PER_W       = 1000;
  localparam int LOAD_MW_PER_MA = 106;
  localparam int LOAD_OFFSET_MW = 1000;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [LVL_W-1:0] IDLE_LEVEL   = LVL_W'(0);
  localparam logic [LVL_W-1:0] CHARGE_LEVEL = LVL_W'(1);

  localparam logic [DEC_W-1:0] DEC_SKIP      = DEC_W'(0);
  localparam logic [DEC_W-1:0] DEC_EMERGENCY = DEC_W'(1);
  localparam logic [DEC_W-1:0] DEC_TARGET    = DEC_W'(2);
  localparam logic [DEC_W-1:0] DEC_CRITICAL  = DEC_W'(3);
  localparam logic [DEC_W-1:0] DEC_FULL      = DEC_W'(4);
  localparam logic [DEC_W-1:0] DEC_LOW       = DEC_W'(5);
  localparam logic [DEC_W-1:0] DEC_MATCH     = DEC_W'(6);

  localparam logic [REG_IDX_W-1:0] REG_MIN_EXCESS   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_MAX_GRID     = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_FULL_SOC     = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_CRITICAL_SOC = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_TARGET_SOC   = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_SETTLE       = REG_IDX_W'(5);

  localparam logic [WATT_W-1:0]  RST_MIN_EXCESS   = WATT_W'(1010);
  localparam logic [WATT_W-1:0]  RST_MAX_GRID     = WATT_W'(1500);
  localparam logic [SOC_W-1:0]   RST_FULL_SOC     = SOC_W'(990);
  localparam logic [SOC_W-1:0]   RST_CRITICAL_SOC = SOC_W'(60);
  localparam logic [SOC_W-1:0]   RST_TARGET_SOC   = SOC_W'(70);
  localparam logic [TICKS_W-1:0] RST_SETTLE       = TICKS_W'(2);

  typedef struct packed {
    logic [WATT_W-1:0]  min_excess_w;
    logic [WATT_W-1:0]  max_grid_draw_w;
    logic [SOC_W-1:0]   full_soc_tenths;
    logic [SOC_W-1:0]   critical_soc_tenths;
    logic [SOC_W-1:0]   charge_target_tenths;
    logic [TICKS_W-1:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic                     data_valid;
    logic                     soc_lt_target;
    logic                     soc_lt_critical;
    logic                     soc_ge_full;
    logic signed [GB_W-1:0]   gb_mw;
    logic signed [GBB_W-1:0]  gbb_mw;
    logic signed [LOAD_W-1:0] load_a_mw;
  } prep_t;

  // Nominal load power of each level in watts; entries past the eighth are empty.
  function automatic logic [PWR_TBL_W-1:0] level_power_w(input logic [IDX_W-1:0] idx);
    logic [PWR_TBL_W-1:0] p;
    case (idx)
      IDX_W'(0): p = PWR_TBL_W'(0);
      IDX_W'(1): p = PWR_TBL_W'(3000);
      IDX_W'(2): p = PWR_TBL_W'(3650);
      IDX_W'(3): p = PWR_TBL_W'(6650);
      IDX_W'(4): p = PWR_TBL_W'(3900);
      IDX_W'(5): p = PWR_TBL_W'(7100);
      IDX_W'(6): p = PWR_TBL_W'(7800);
      IDX_W'(7): p = PWR_TBL_W'(11400);
      default:   p = PWR_TBL_W'(0);
    endcase
    return p;
  endfunction

  function automatic logic [PWR_MW_W-1:0] level_power_mw(input logic [IDX_W-1:0] idx);
    return PWR_MW_W'(int'(level_power_w(idx)) * MW_PER_W);
  endfunction

endpackage

`default_nettype wire

// ===== sv/brlc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Relay level controller configuration registers
// APB-style register file holding the thresholds and the settling count.
// ----------------------------------------------------------------------------
`default_nettype none

module brlc_cfg_regs (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [brlc_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire  [brlc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [brlc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output brlc_pkg::cfg_t                     cfg
);

  brlc_pkg::cfg_t                     cfg_r;
  logic                               wr_en;
  logic [brlc_pkg::REG_IDX_W-1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[brlc_pkg::APB_ADDR_W-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_excess_w         <= brlc_pkg::RST_MIN_EXCESS;
      cfg_r.max_grid_draw_w      <= brlc_pkg::RST_MAX_GRID;
      cfg_r.full_soc_tenths      <= brlc_pkg::RST_FULL_SOC;
      cfg_r.critical_soc_tenths  <= brlc_pkg::RST_CRITICAL_SOC;
      cfg_r.charge_target_tenths <= brlc_pkg::RST_TARGET_SOC;
      cfg_r.settle_ticks         <= brlc_pkg::RST_SETTLE;
    end else if (wr_en) begin
      case (reg_idx)
        brlc_pkg::REG_MIN_EXCESS:
          cfg_r.min_excess_w <= pwdata[brlc_pkg::WATT_W-1:0];
        brlc_pkg::REG_MAX_GRID:
          cfg_r.max_grid_draw_w <= pwdata[brlc_pkg::WATT_W-1:0];
        brlc_pkg::REG_FULL_SOC:
          cfg_r.full_soc_tenths <= pwdata[brlc_pkg::SOC_W-1:0];
        brlc_pkg::REG_CRITICAL_SOC:
          cfg_r.critical_soc_tenths <= pwdata[brlc_pkg::SOC_W-1:0];
        brlc_pkg::REG_TARGET_SOC:
          cfg_r.charge_target_tenths <= pwdata[brlc_pkg::SOC_W-1:0];
        brlc_pkg::REG_SETTLE:
          cfg_r.settle_ticks <= pwdata[brlc_pkg::TICKS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      brlc_pkg::REG_MIN_EXCESS:   prdata = brlc_pkg::APB_DATA_W'(cfg_r.min_excess_w);
      brlc_pkg::REG_MAX_GRID:     prdata = brlc_pkg::APB_DATA_W'(cfg_r.max_grid_draw_w);
      brlc_pkg::REG_FULL_SOC:     prdata = brlc_pkg::APB_DATA_W'(cfg_r.full_soc_tenths);
      brlc_pkg::REG_CRITICAL_SOC: prdata = brlc_pkg::APB_DATA_W'(cfg_r.critical_soc_tenths);
      brlc_pkg::REG_TARGET_SOC:   prdata = brlc_pkg::APB_DATA_W'(cfg_r.charge_target_tenths);
      brlc_pkg::REG_SETTLE:       prdata = brlc_pkg::APB_DATA_W'(cfg_r.settle_ticks);
      default:                    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/brlc_prep.sv =====
// ----------------------------------------------------------------------------
// Relay level controller input stage
// Registers the input word and works out everything that does not depend on
// the present relay level: power sums in milliwatts and charge comparisons.
// ----------------------------------------------------------------------------
`default_nettype none

module brlc_prep (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  in_data_valid,
  input  wire         [brlc_pkg::SOC_W-1:0]    in_soc_tenths,
  input  wire  signed [brlc_pkg::PWR_W-1:0]    in_grid_power_w,
  input  wire  signed [brlc_pkg::PWR_W-1:0]    in_battery_power_w,
  input  wire  signed [brlc_pkg::CUR_W-1:0]    in_battery_current_ma,
  input  brlc_pkg::cfg_t                       cfg,
  output logic                                 prep_valid,
  output brlc_pkg::prep_t                      prep,
  input  wire                                  prep_ready
);

  logic                                 in_v_r;
  logic                                 dv_r;
  logic        [brlc_pkg::SOC_W-1:0]    soc_r;
  logic signed [brlc_pkg::PWR_W-1:0]    grid_r;
  logic signed [brlc_pkg::PWR_W-1:0]    bat_r;
  logic signed [brlc_pkg::CUR_W-1:0]    cur_r;

  logic                                 prep_v_r;
  brlc_pkg::prep_t                      prep_r;
  brlc_pkg::prep_t                      prep_nxt;
  logic                                 prep_load;

  logic signed [brlc_pkg::PW_SUM_W-1:0] pw_sum;
  logic signed [brlc_pkg::GBB_W-1:0]    grid_draw_mw;

  assign prep_load  = !prep_v_r || prep_ready;
  assign in_ready   = !in_v_r || prep_load;
  assign prep_valid = prep_v_r;
  assign prep       = prep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      prep_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (prep_load) begin
        prep_v_r <= in_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dv_r   <= in_data_valid;
      soc_r  <= in_soc_tenths;
      grid_r <= in_grid_power_w;
      bat_r  <= in_battery_power_w;
      cur_r  <= in_battery_current_ma;
    end
    if (prep_load && in_v_r) begin
      prep_r <= prep_nxt;
    end
  end

  // Grid and battery powers are summed in watts first; the scaling to
  // milliwatts is exact, so the order does not change the result.
  assign pw_sum = brlc_pkg::PW_SUM_W'(grid_r) + brlc_pkg::PW_SUM_W'(bat_r);
  assign grid_draw_mw = brlc_pkg::GBB_W'($signed({1'b0, cfg.max_grid_draw_w}))
                      * brlc_pkg::GBB_W'(brlc_pkg::MW_PER_W);

  always_comb begin
    prep_nxt.data_valid      = dv_r;
    prep_nxt.soc_lt_target   = soc_r < cfg.charge_target_tenths;
    prep_nxt.soc_lt_critical = soc_r < cfg.critical_soc_tenths;
    prep_nxt.soc_ge_full     = soc_r >= cfg.full_soc_tenths;
    prep_nxt.gb_mw           = brlc_pkg::GB_W'(pw_sum) * brlc_pkg::GB_W'(brlc_pkg::MW_PER_W);
    prep_nxt.gbb_mw          = brlc_pkg::GBB_W'(prep_nxt.gb_mw) + grid_draw_mw;
    prep_nxt.load_a_mw       = brlc_pkg::LOAD_W'(cur_r)
                             * brlc_pkg::LOAD_W'(brlc_pkg::LOAD_MW_PER_MA)
                             + brlc_pkg::LOAD_W'(brlc_pkg::LOAD_OFFSET_MW);
  end

endmodule

`default_nettype wire

// ===== sv/brlc_decide.sv =====
// ----------------------------------------------------------------------------
// Relay level controller decision stage
// Completes the excess power with the load of the present level, chooses the
// candidate level, applies ramp limiting and settling, and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module brlc_decide #(
  parameter int LEVELS = brlc_pkg::LEVELS_DEFAULT
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  brlc_pkg::cfg_t                        cfg,
  input  wire                                   prep_valid,
  output logic                                  prep_ready,
  input  brlc_pkg::prep_t                       prep,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic        [brlc_pkg::LVL_W-1:0]     out_relay_level,
  output logic                                  out_level_changed,
  output logic        [brlc_pkg::DEC_W-1:0]     out_decision,
  output logic                                  out_ramp_capped,
  output logic                                  out_protection_active,
  output logic        [brlc_pkg::CNT_W-1:0]     out_settle_count,
  output logic signed [brlc_pkg::EXCESS_W-1:0]  out_excess_mw
);

  // Power of a level as this instance sees it: levels at or past LEVELS are empty.
  function automatic logic [brlc_pkg::PWR_TBL_W-1:0] lvl_power_w(
    input logic [brlc_pkg::LVL_W-1:0] lv
  );
    logic [brlc_pkg::PWR_TBL_W-1:0] p;
    p = '0;
    if (int'(lv) < LEVELS) begin
      p = brlc_pkg::level_power_w(brlc_pkg::IDX_W'(lv));
    end
    return p;
  endfunction

  function automatic logic [brlc_pkg::PWR_MW_W-1:0] lvl_power_mw(
    input logic [brlc_pkg::LVL_W-1:0] lv
  );
    logic [brlc_pkg::PWR_MW_W-1:0] p;
    p = '0;
    if (int'(lv) < LEVELS) begin
      p = brlc_pkg::level_power_mw(brlc_pkg::IDX_W'(lv));
    end
    return p;
  endfunction

  // Highest table power within the budget, lowest index among equal powers.
  // Each level decides on its own whether another fitting level beats it.
  function automatic logic [brlc_pkg::LVL_W-1:0] best_match(
    input logic signed [brlc_pkg::BUDGET_W-1:0] budget
  );
    logic [LEVELS-1:0]               fit;
    logic                            dom;
    logic [brlc_pkg::PWR_TBL_W-1:0]  pi;
    logic [brlc_pkg::PWR_TBL_W-1:0]  pj;
    logic [brlc_pkg::LVL_W-1:0]      best;
    best = '0;
    for (int i = 0; i < LEVELS; i++) begin
      fit[i] = (brlc_pkg::level_power_w(brlc_pkg::IDX_W'(i)) != '0) &&
               (brlc_pkg::BUDGET_W'($signed({1'b0,
                 brlc_pkg::level_power_mw(brlc_pkg::IDX_W'(i))})) <= budget);
    end
    for (int i = 0; i < LEVELS; i++) begin
      pi  = brlc_pkg::level_power_w(brlc_pkg::IDX_W'(i));
      dom = 1'b0;
      for (int j = 0; j < LEVELS; j++) begin
        pj = brlc_pkg::level_power_w(brlc_pkg::IDX_W'(j));
        if ((fit[j] && (pj > pi)) || ((j < i) && (pj == pi))) begin
          dom = 1'b1;
        end
      end
      if (fit[i] && !dom) begin
        best = brlc_pkg::LVL_W'(i);
      end
    end
    return best;
  endfunction

  // Smallest table power above that of the present level, lowest index on ties.
  function automatic logic [brlc_pkg::LVL_W-1:0] next_up(
    input logic [brlc_pkg::LVL_W-1:0] lv
  );
    logic [LEVELS-1:0]               above;
    logic                            dom;
    logic [brlc_pkg::PWR_TBL_W-1:0]  cur_p;
    logic [brlc_pkg::PWR_TBL_W-1:0]  pi;
    logic [brlc_pkg::PWR_TBL_W-1:0]  pj;
    logic [brlc_pkg::LVL_W-1:0]      nxt;
    cur_p = lvl_power_w(lv);
    nxt   = lv;
    for (int i = 0; i < LEVELS; i++) begin
      above[i] = brlc_pkg::level_power_w(brlc_pkg::IDX_W'(i)) > cur_p;
    end
    for (int i = 0; i < LEVELS; i++) begin
      pi  = brlc_pkg::level_power_w(brlc_pkg::IDX_W'(i));
      dom = 1'b0;
      for (int j = 0; j < LEVELS; j++) begin
        pj = brlc_pkg::level_power_w(brlc_pkg::IDX_W'(j));
        if (above[j] && ((pj < pi) || ((pj == pi) && (j < i)))) begin
          dom = 1'b1;
        end
      end
      if (above[i] && !dom) begin
        nxt = brlc_pkg::LVL_W'(i);
      end
    end
    return nxt;
  endfunction

  logic [brlc_pkg::LVL_W-1:0]           level_r;
  logic [brlc_pkg::CNT_W-1:0]           cnt_r;
  logic                                 latch_r;
  logic                                 out_v_r;

  logic [brlc_pkg::LVL_W-1:0]           level_nxt;
  logic [brlc_pkg::CNT_W-1:0]           cnt_nxt;
  logic                                 latch_nxt;
  logic                                 changed_nxt;
  logic [brlc_pkg::DEC_W-1:0]           dec_nxt;
  logic                                 ramp_nxt;
  logic signed [brlc_pkg::EXCESS_W-1:0] excess_nxt;

  logic [brlc_pkg::LVL_W-1:0]           out_level_r;
  logic                                 out_changed_r;
  logic [brlc_pkg::DEC_W-1:0]           out_dec_r;
  logic                                 out_ramp_r;
  logic                                 out_latch_r;
  logic [brlc_pkg::CNT_W-1:0]           out_cnt_r;
  logic signed [brlc_pkg::EXCESS_W-1:0] out_excess_r;

  logic signed [brlc_pkg::LOAD_W-1:0]   load_b;
  logic signed [brlc_pkg::LOAD_W-1:0]   load;
  logic signed [brlc_pkg::EXCESS_W-1:0] excess;
  logic signed [brlc_pkg::BUDGET_W-1:0] budget;
  logic signed [brlc_pkg::BUDGET_W-1:0] min_mw;
  logic [brlc_pkg::LVL_W-1:0]           best;
  logic [brlc_pkg::LVL_W-1:0]           nx;
  logic [brlc_pkg::LVL_W-1:0]           cand;
  logic [brlc_pkg::CNT_W-1:0]           cnt_inc;
  logic                                 fire;

  assign prep_ready = !out_v_r || out_ready;
  assign fire       = prep_valid && prep_ready;

  assign load_b = brlc_pkg::LOAD_W'($signed({1'b0, lvl_power_mw(level_r)}));
  assign min_mw = brlc_pkg::BUDGET_W'($signed({1'b0, cfg.min_excess_w}))
                * brlc_pkg::BUDGET_W'(brlc_pkg::MW_PER_W);

  always_comb begin
    // Level 0 draws nothing; otherwise the measured draw, floored at the table power.
    if (level_r == brlc_pkg::IDLE_LEVEL) begin
      load = '0;
    end else if (prep.load_a_mw > load_b) begin
      load = prep.load_a_mw;
    end else begin
      load = load_b;
    end
    excess = brlc_pkg::EXCESS_W'(prep.gb_mw) + brlc_pkg::EXCESS_W'(load);
    budget = brlc_pkg::BUDGET_W'(prep.gbb_mw) + brlc_pkg::BUDGET_W'(load);
    best   = best_match(budget);
    nx     = next_up(level_r);

    latch_nxt = latch_r;
    ramp_nxt  = 1'b0;
    if (latch_r) begin
      if (prep.soc_lt_target) begin
        cand    = brlc_pkg::CHARGE_LEVEL;
        dec_nxt = brlc_pkg::DEC_EMERGENCY;
      end else begin
        cand      = brlc_pkg::IDLE_LEVEL;
        latch_nxt = 1'b0;
        dec_nxt   = brlc_pkg::DEC_TARGET;
      end
    end else if (prep.soc_lt_critical) begin
      cand      = brlc_pkg::CHARGE_LEVEL;
      latch_nxt = 1'b1;
      dec_nxt   = brlc_pkg::DEC_CRITICAL;
    end else if (prep.soc_ge_full) begin
      cand    = brlc_pkg::IDLE_LEVEL;
      dec_nxt = brlc_pkg::DEC_FULL;
    end else if (brlc_pkg::BUDGET_W'(excess) < min_mw) begin
      cand    = brlc_pkg::IDLE_LEVEL;
      dec_nxt = brlc_pkg::DEC_LOW;
    end else begin
      cand    = best;
      dec_nxt = brlc_pkg::DEC_MATCH;
      if ((best > level_r) && (best > nx)) begin
        cand     = nx;
        ramp_nxt = 1'b1;
      end
    end

    cnt_inc     = cnt_r + brlc_pkg::CNT_W'(1);
    level_nxt   = level_r;
    cnt_nxt     = '0;
    changed_nxt = 1'b0;
    excess_nxt  = excess;
    if (cand != level_r) begin
      cnt_nxt = cnt_inc;
      if (cnt_inc >= cfg.settle_ticks) begin
        level_nxt   = cand;
        cnt_nxt     = '0;
        changed_nxt = 1'b1;
      end
    end

    // A stale measurement leaves all state as it was.
    if (!prep.data_valid) begin
      level_nxt   = level_r;
      cnt_nxt     = cnt_r;
      latch_nxt   = latch_r;
      changed_nxt = 1'b0;
      dec_nxt     = brlc_pkg::DEC_SKIP;
      ramp_nxt    = 1'b0;
      excess_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= brlc_pkg::IDLE_LEVEL;
      cnt_r   <= '0;
      latch_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (prep_ready) begin
        out_v_r <= prep_valid;
      end
      if (fire) begin
        level_r <= level_nxt;
        cnt_r   <= cnt_nxt;
        latch_r <= latch_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_level_r   <= level_nxt;
      out_changed_r <= changed_nxt;
      out_dec_r     <= dec_nxt;
      out_ramp_r    <= ramp_nxt;
      out_latch_r   <= latch_nxt;
      out_cnt_r     <= cnt_nxt;
      out_excess_r  <= excess_nxt;
    end
  end

  assign out_valid             = out_v_r;
  assign out_relay_level       = out_level_r;
  assign out_level_changed     = out_changed_r;
  assign out_decision          = out_dec_r;
  assign out_ramp_capped       = out_ramp_r;
  assign out_protection_active = out_latch_r;
  assign out_settle_count      = out_cnt_r;
  assign out_excess_mw         = out_excess_r;

endmodule

`default_nettype wire

// ===== sv/battery_relay_level_controller.sv =====
// ----------------------------------------------------------------------------
// Battery relay level controller
// Each input word is one control tick of grid power, battery power, battery
// current and lowest charge; each tick yields one result word with the relay
// level (0 to 7), the reason for it and the excess power in milliwatts. The
// block takes one word per clock cycle when the result side keeps up; a word
// passes through an input register, a register after the level-independent
// power arithmetic, and the result register, which also holds the level,
// settling count and protection latch that the next tick reads. Thresholds are
// written through the APB-style port at byte addresses 0 to 20; the user must
// write them only while no tick is in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_relay_level_controller #(
  parameter int LEVELS = brlc_pkg::LEVELS_DEFAULT
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire                                   in_data_valid,
  input  wire         [brlc_pkg::SOC_W-1:0]     in_soc_tenths,
  input  wire  signed [brlc_pkg::PWR_W-1:0]     in_grid_power_w,
  input  wire  signed [brlc_pkg::PWR_W-1:0]     in_battery_power_w,
  input  wire  signed [brlc_pkg::CUR_W-1:0]     in_battery_current_ma,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic        [brlc_pkg::LVL_W-1:0]     out_relay_level,
  output logic                                  out_level_changed,
  output logic        [brlc_pkg::DEC_W-1:0]     out_decision,
  output logic                                  out_ramp_capped,
  output logic                                  out_protection_active,
  output logic        [brlc_pkg::CNT_W-1:0]     out_settle_count,
  output logic signed [brlc_pkg::EXCESS_W-1:0]  out_excess_mw,
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire         [brlc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire         [brlc_pkg::APB_DATA_W-1:0] pwdata,
  output logic        [brlc_pkg::APB_DATA_W-1:0] prdata,
  output logic                                  pready
);

  brlc_pkg::cfg_t  cfg;
  brlc_pkg::prep_t prep;
  logic            prep_valid;
  logic            prep_ready;

  brlc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  brlc_prep u_prep (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_data_valid         (in_data_valid),
    .in_soc_tenths         (in_soc_tenths),
    .in_grid_power_w       (in_grid_power_w),
    .in_battery_power_w    (in_battery_power_w),
    .in_battery_current_ma (in_battery_current_ma),
    .cfg                   (cfg),
    .prep_valid            (prep_valid),
    .prep                  (prep),
    .prep_ready            (prep_ready)
  );

  brlc_decide #(
    .LEVELS (LEVELS)
  ) u_decide (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg),
    .prep_valid            (prep_valid),
    .prep_ready            (prep_ready),
    .prep                  (prep),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_relay_level       (out_relay_level),
    .out_level_changed     (out_level_changed),
    .out_decision          (out_decision),
    .out_ramp_capped       (out_ramp_capped),
    .out_protection_active (out_protection_active),
    .out_settle_count      (out_settle_count),
    .out_excess_mw         (out_excess_mw)
  );

endmodule

`default_nettype wire

// ===== sv/brlc_checker.sv =====
// ----------------------------------------------------------------------------
// Relay level controller checker
// Port-level assertions on the result words, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module brlc_checker (
  input wire                                  clk,
  input wire                                  rst_n,
  input wire                                  out_valid,
  input wire                                  out_ready,
  input wire        [brlc_pkg::LVL_W-1:0]     out_relay_level,
  input wire                                  out_level_changed,
  input wire        [brlc_pkg::DEC_W-1:0]     out_decision,
  input wire                                  out_ramp_capped,
  input wire                                  out_protection_active,
  input wire        [brlc_pkg::CNT_W-1:0]     out_settle_count,
  input wire signed [brlc_pkg::EXCESS_W-1:0]  out_excess_mw
);

  localparam int WORD_W = brlc_pkg::LVL_W + brlc_pkg::DEC_W + brlc_pkg::CNT_W
                        + brlc_pkg::EXCESS_W + 3;

  logic [WORD_W-1:0] out_word;
  logic              stalled;
  logic              switched;
  logic              skipped;
  logic              quiet;
  logic              latch_dec;
  logic              latch_agrees;
  logic              ramp_seen;

  assign out_word     = {out_relay_level, out_level_changed, out_decision, out_ramp_capped,
                         out_protection_active, out_settle_count, out_excess_mw};
  assign stalled      = out_valid && !out_ready;
  assign switched     = out_valid && out_level_changed;
  assign skipped      = out_valid && (out_decision == brlc_pkg::DEC_SKIP);
  assign quiet        = !out_level_changed && !out_ramp_capped && (out_excess_mw == '0);
  assign latch_dec    = out_valid && (out_decision inside {brlc_pkg::DEC_EMERGENCY,
                                                           brlc_pkg::DEC_CRITICAL,
                                                           brlc_pkg::DEC_TARGET});
  assign latch_agrees = out_protection_active == (out_decision != brlc_pkg::DEC_TARGET);
  assign ramp_seen    = out_valid && out_ramp_capped;

  // A stalled result word stays on the port.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, out_valid && $stable(out_word))

  // A switch restarts the settling count.
  `ASSERT_IMPLY(a_switch_clears_count, clk, rst_n, switched, out_settle_count == '0)

  // A skipped tick changes nothing and reports no excess.
  `ASSERT_IMPLY(a_skip_quiet, clk, rst_n, skipped, quiet)

  // The protection latch agrees with the decision that set or released it.
  `ASSERT_IMPLY(a_latch_decision, clk, rst_n, latch_dec, latch_agrees)

  // Ramp limiting only happens in power matching.
  `ASSERT_IMPLY(a_ramp_only_match, clk, rst_n, ramp_seen, out_decision == brlc_pkg::DEC_MATCH)

endmodule

bind battery_relay_level_controller brlc_checker u_brlc_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_relay_level       (out_relay_level),
  .out_level_changed     (out_level_changed),
  .out_decision          (out_decision),
  .out_ramp_capped       (out_ramp_capped),
  .out_protection_active (out_protection_active),
  .out_settle_count      (out_settle_count),
  .out_excess_mw         (out_excess_mw)
);

`default_nettype wire

// ===== tb/tb_battery_relay_level_controller.sv =====
// ----------------------------------------------------------------------------
// Relay level controller testbench
// Drives control ticks through the valid/ready input channel and checks each
// result word against an in-bench predictor of level, decision, protection
// latch, settling count and excess power. The thresholds are rewritten over
// the APB-style port between phases. The phases cover reset values, both
// extremes, a zero settling count and random settings. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_battery_relay_level_controller;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LOAD_SLOPE   = 106;
  localparam int LOAD_BASE_MW = 1000;

  typedef struct packed {
    logic                              dv;
    logic [brlc_pkg::SOC_W-1:0]        soc;
    logic signed [brlc_pkg::PWR_W-1:0] grid;
    logic signed [brlc_pkg::PWR_W-1:0] bat;
    logic signed [brlc_pkg::CUR_W-1:0] cur;
  } tick_t;

  typedef struct packed {
    logic [brlc_pkg::LVL_W-1:0]           level;
    logic                                 changed;
    logic [brlc_pkg::DEC_W-1:0]           decision;
    logic                                 ramp;
    logic                                 prot;
    logic [brlc_pkg::CNT_W-1:0]           count;
    logic signed [brlc_pkg::EXCESS_W-1:0] excess;
  } outcome_t;

  // Tracks the controller state and holds the results still to come.
  class relay_level_tracker;
    int unsigned min_excess_w, max_grid_w, full_soc, crit_soc, target_soc;
    int unsigned settle_ticks;
    int unsigned level_now, settle_now, latch_now;
    int          level_w[8] = '{0, 3000, 3650, 6650, 3900, 7100, 7800, 11400};
    outcome_t    awaited_outcomes[$];
    int          mismatches;

    function new();
      min_excess_w = 1010;
      max_grid_w   = 1500;
      full_soc     = 990;
      crit_soc     = 60;
      target_soc   = 70;
      settle_ticks = 2;
      level_now    = 0;
      settle_now   = 0;
      latch_now    = 0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [brlc_pkg::REG_IDX_W-1:0] idx, int unsigned value);
      case (idx)
        brlc_pkg::REG_MIN_EXCESS:   min_excess_w = value & 32'h7FFF;
        brlc_pkg::REG_MAX_GRID:     max_grid_w   = value & 32'h7FFF;
        brlc_pkg::REG_FULL_SOC:     full_soc     = value & 32'h3FF;
        brlc_pkg::REG_CRITICAL_SOC: crit_soc     = value & 32'h3FF;
        brlc_pkg::REG_TARGET_SOC:   target_soc   = value & 32'h3FF;
        brlc_pkg::REG_SETTLE:       settle_ticks = value & 32'hF;
        default: ;
      endcase
    endfunction

    function void note_tick(tick_t t);
      outcome_t o;
      longint   load, excess, budget, pa, pb, best_p, cur_p, nxt_p;
      int       cand, best, nxt, i;
      o = '0;
      if (!t.dv) begin
        o.level = brlc_pkg::LVL_W'(level_now);
        o.prot  = latch_now[0];
        o.count = brlc_pkg::CNT_W'(settle_now);
        awaited_outcomes.push_back(o);
        return;
      end
      // Load draw only counts while some relay is closed.
      load = 0;
      if (level_now != 0) begin
        pa = longint'(t.cur) * LOAD_SLOPE + LOAD_BASE_MW;
        pb = longint'(level_w[level_now]) * 1000;
        load = (pa > pb) ? pa : pb;
      end
      excess = longint'(t.grid) * 1000 + load + longint'(t.bat) * 1000;
      if (latch_now != 0) begin
        if (t.soc < target_soc) begin
          cand = 1;
          o.decision = brlc_pkg::DEC_EMERGENCY;
        end else begin
          cand = 0;
          latch_now = 0;
          o.decision = brlc_pkg::DEC_TARGET;
        end
      end else if (t.soc < crit_soc) begin
        cand = 1;
        latch_now = 1;
        o.decision = brlc_pkg::DEC_CRITICAL;
      end else if (t.soc >= full_soc) begin
        cand = 0;
        o.decision = brlc_pkg::DEC_FULL;
      end else if (excess < longint'(min_excess_w) * 1000) begin
        cand = 0;
        o.decision = brlc_pkg::DEC_LOW;
      end else begin
        budget = excess + longint'(max_grid_w) * 1000;
        best   = 0;
        best_p = 0;
        for (i = 0; i < 8; i++) begin
          if (longint'(level_w[i]) * 1000 <= budget && level_w[i] > best_p) begin
            best   = i;
            best_p = level_w[i];
          end
        end
        // Climbing is limited to the level with the next higher power.
        if (best > int'(level_now)) begin
          cur_p = level_w[level_now];
          nxt_p = cur_p;
          nxt   = level_now;
          for (i = 0; i < 8; i++) begin
            if (level_w[i] > cur_p && (level_w[i] < nxt_p || nxt_p == cur_p)) begin
              nxt   = i;
              nxt_p = level_w[i];
            end
          end
          if (best > nxt) begin
            best   = nxt;
            o.ramp = 1'b1;
          end
        end
        cand = best;
        o.decision = brlc_pkg::DEC_MATCH;
      end
      if (cand != int'(level_now)) begin
        settle_now = (settle_now + 1) & 15;
        if (settle_now >= settle_ticks) begin
          level_now  = cand & 7;
          settle_now = 0;
          o.changed  = 1'b1;
        end
      end else begin
        settle_now = 0;
      end
      o.level  = brlc_pkg::LVL_W'(level_now);
      o.prot   = latch_now[0];
      o.count  = brlc_pkg::CNT_W'(settle_now);
      o.excess = brlc_pkg::EXCESS_W'(excess);
      awaited_outcomes.push_back(o);
    endfunction

    function void compare_field(string field, longint want, longint got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      if (awaited_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: result word with nothing expected, level %0d decision %0d",
                 $time, got.level, got.decision);
        return;
      end
      want = awaited_outcomes.pop_front();
      compare_field("relay_level", want.level, got.level);
      compare_field("level_changed", want.changed, got.changed);
      compare_field("decision", want.decision, got.decision);
      compare_field("ramp_capped", want.ramp, got.ramp);
      compare_field("protection_active", want.prot, got.prot);
      compare_field("settle_count", want.count, got.count);
      compare_field("excess_mw", want.excess, got.excess);
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;

  logic                              in_valid              = 1'b0;
  logic                              in_ready;
  logic                              in_data_valid         = 1'b0;
  logic [brlc_pkg::SOC_W-1:0]        in_soc_tenths         = '0;
  logic signed [brlc_pkg::PWR_W-1:0] in_grid_power_w       = '0;
  logic signed [brlc_pkg::PWR_W-1:0] in_battery_power_w    = '0;
  logic signed [brlc_pkg::CUR_W-1:0] in_battery_current_ma = '0;

  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic [brlc_pkg::LVL_W-1:0]           out_relay_level;
  logic                                 out_level_changed;
  logic [brlc_pkg::DEC_W-1:0]           out_decision;
  logic                                 out_ramp_capped;
  logic                                 out_protection_active;
  logic [brlc_pkg::CNT_W-1:0]           out_settle_count;
  logic signed [brlc_pkg::EXCESS_W-1:0] out_excess_mw;

  logic                            psel    = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite  = 1'b0;
  logic [brlc_pkg::APB_ADDR_W-1:0] paddr   = '0;
  logic [brlc_pkg::APB_DATA_W-1:0] pwdata  = '0;
  logic [brlc_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  relay_level_tracker tracker;
  logic               steady = 1'b0;
  int                 ready_hold = 0;
  int                 cycles = 0;

  battery_relay_level_controller u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_data_valid         (in_data_valid),
    .in_soc_tenths         (in_soc_tenths),
    .in_grid_power_w       (in_grid_power_w),
    .in_battery_power_w    (in_battery_power_w),
    .in_battery_current_ma (in_battery_current_ma),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_relay_level       (out_relay_level),
    .out_level_changed     (out_level_changed),
    .out_decision          (out_decision),
    .out_ramp_capped       (out_ramp_capped),
    .out_protection_active (out_protection_active),
    .out_settle_count      (out_settle_count),
    .out_excess_mw         (out_excess_mw),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Mostly short spans, now and then a long one.
  function automatic int rand_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic int pick_gap();
    if (steady || $urandom_range(0, 99) < 50) return 0;
    return rand_span();
  endfunction

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic tick_t mk(int dv, int soc, int grid, int bat, int cur);
    tick_t t;
    t.dv   = dv[0];
    t.soc  = brlc_pkg::SOC_W'(soc);
    t.grid = brlc_pkg::PWR_W'(grid);
    t.bat  = brlc_pkg::PWR_W'(bat);
    t.cur  = brlc_pkg::CUR_W'(cur);
    return t;
  endfunction

  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_hold = rand_span();
      out_ready <= steady || ($urandom_range(0, 99) < 65);
    end else begin
      ready_hold = ready_hold - 1;
    end
  end

  // Both handshakes are sampled at the edge, before any new drive takes effect.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        tracker.note_tick({in_data_valid, in_soc_tenths, in_grid_power_w,
                           in_battery_power_w, in_battery_current_ma});
      if (out_valid && out_ready)
        tracker.check_outcome({out_relay_level, out_level_changed, out_decision,
                               out_ramp_capped, out_protection_active,
                               out_settle_count, out_excess_mw});
    end
  end

  task automatic send_tick(input tick_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_data_valid         <= t.dv;
    in_soc_tenths         <= t.soc;
    in_grid_power_w       <= t.grid;
    in_battery_power_w    <= t.bat;
    in_battery_current_ma <= t.cur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [brlc_pkg::REG_IDX_W-1:0] idx,
                           input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.write_reg(idx, value);
    @(posedge clk);
  endtask

  // The first edge lets the monitor note the word accepted at the last one.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.awaited_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_thresholds(input int unsigned min_ex, input int unsigned max_grid,
                                  input int unsigned full, input int unsigned crit,
                                  input int unsigned target, input int unsigned settle);
    drain_results();
    write_reg(brlc_pkg::REG_MIN_EXCESS, min_ex);
    write_reg(brlc_pkg::REG_MAX_GRID, max_grid);
    write_reg(brlc_pkg::REG_FULL_SOC, full);
    write_reg(brlc_pkg::REG_CRITICAL_SOC, crit);
    write_reg(brlc_pkg::REG_TARGET_SOC, target);
    write_reg(brlc_pkg::REG_SETTLE, settle);
  endtask

  // Each scene holds roughly steady conditions for a run of ticks so that the
  // settling count can complete; charge drifts to walk through the latch.
  task automatic run_scenes(input int count);
    int left, run, r, s, g, b, c, step;
    left = count;
    while (left > 0) begin
      steady <= ($urandom_range(0, 9) == 0);
      run = $urandom_range(1, 16);
      r = $urandom_range(0, 99);
      if (r < 10)
        s = $urandom_range(0, 1000);
      else if (r < 32)
        s = clampi(int'(tracker.crit_soc) + $urandom_range(0, 20) - 8, 0, 1000);
      else if (r < 42)
        s = clampi(int'(tracker.full_soc) + $urandom_range(0, 6) - 3, 0, 1000);
      else
        s = $urandom_range(100, 950);
      step = (r >= 10 && r < 32) ? $urandom_range(0, 3) : $urandom_range(0, 2) - 1;
      if ($urandom_range(0, 9) == 0) begin
        g = $signed(brlc_pkg::PWR_W'($urandom));
        b = $signed(brlc_pkg::PWR_W'($urandom));
        c = $urandom_range(0, 400000) - 200000;
      end else begin
        g = $urandom_range(0, 24000) - 8000;
        b = $urandom_range(0, 12000) - 6000;
        c = $urandom_range(0, 120000) - 60000;
      end
      repeat (run) begin
        if (left > 0) begin
          send_tick(mk(($urandom_range(0, 99) < 92),
                       s,
                       clampi(g + $urandom_range(0, 400) - 200, -32768, 32767),
                       clampi(b + $urandom_range(0, 400) - 200, -32768, 32767),
                       clampi(c + $urandom_range(0, 4000) - 2000, -200000, 200000)));
          s = clampi(s + step, 0, 1000);
          left--;
        end
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset thresholds.
    send_tick(mk(0, 1000, 32767, 32767, 200000));
    send_tick(mk(1, 500, 0, 0, 0));
    repeat (6) send_tick(mk(1, 500, 20000, 0, 0));
    send_tick(mk(1, 500, 32767, 32767, 200000));
    repeat (2) send_tick(mk(1, 500, -32768, -32768, -200000));
    send_tick(mk(0, 0, -32768, -32768, -200000));
    send_tick(mk(1, 500, 1010, 0, 0));
    send_tick(mk(1, 500, 1009, 0, 0));
    repeat (2) send_tick(mk(1, 1000, 5000, 0, 1000));
    send_tick(mk(1, 989, 5000, 0, 1000));
    send_tick(mk(1, 0, 0, 0, 0));
    repeat (2) send_tick(mk(1, 69, 0, 0, 0));
    send_tick(mk(1, 70, 0, 0, 0));
    send_tick(mk(1, 60, 0, 0, 0));
    send_tick(mk(1, 59, 0, 0, 0));
    send_tick(mk(1, 1000, 0, 0, 0));

    run_scenes(250);
    apply_thresholds(0, 0, 1000, 0, 0, 1);
    run_scenes(120);
    apply_thresholds(20000, 20000, 0, 1000, 1000, 15);
    run_scenes(120);
    // A zero settling count switches on the first differing decision.
    apply_thresholds(500, 3000, 950, 100, 150, 0);
    run_scenes(200);
    repeat (3) begin
      int unsigned crit;
      crit = $urandom_range(0, 300);
      apply_thresholds($urandom_range(0, 20000), $urandom_range(0, 20000),
                       $urandom_range(700, 1000), crit, crit + $urandom_range(0, 100),
                       ($urandom_range(0, 2) == 0) ? $urandom_range(1, 15)
                                                   : $urandom_range(1, 3));
      run_scenes(220);
    end

    drain_results();
    if (tracker.mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== battery_relay_level_controller.f =====
+incdir+sv
sv/brlc_pkg.sv
sv/brlc_cfg_regs.sv
sv/brlc_prep.sv
sv/brlc_decide.sv
sv/battery_relay_level_controller.sv
sv/brlc_checker.sv
tb/tb_battery_relay_level_controller.sv
